@@ sv/olsk_pkg.sv @@
`timescale 1ns / 1ps
package olsk_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_KTH    = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_ARG   = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] value;
		logic [15:0] step_k;
		logic [5:0]  index;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  length;
		logic [31:0] read_value;
	} out_word_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_WALK = 2'd1,
		FSM_DONE = 2'd2
	} fsm_t;

	// per-cycle command to every cell in the chain
	typedef struct packed {
		logic load;   // write the cell just past the held block (append)
		logic rotate; // held block rotates one place; front word goes to its tail
		logic drop;   // held block shifts one place toward the front; front word lost
	} cell_cmd_t;

endpackage

@@ sv/olsk_cell.sv @@
`timescale 1ns / 1ps
// One storage slot; loads d when take is high (the store feeds it the upper neighbor on shift/rotate).
module olsk_cell #(
	parameter int VALUE_BITS = olsk_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  take,
	input  logic [VALUE_BITS-1:0] d,
	output logic [VALUE_BITS-1:0] q
);

	logic [VALUE_BITS-1:0] data_q;

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

@@ sv/ordered_list_store_with_kth_removal.sv @@
`timescale 1ns / 1ps
// Append and refused requests pass through WALK, which walks nothing, and DONE,
// which loads the result. Remove by value, remove every kth and a valid read
// walk the held entries through the front cell, one per cycle, in WALK.
// A new word is taken the cycle after the result is loaded; a waiting result
// only delays the load of the next one. Reset clears the entry count, control
// and output valid; entry data is not reset.
module ordered_list_store_with_kth_removal #(
	parameter int CAPACITY   = olsk_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = olsk_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  olsk_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output olsk_pkg::out_word_t out_data
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 6) ? CW : 6;

	logic [VALUE_BITS-1:0] cq [CAPACITY];

	olsk_pkg::fsm_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] step_q, step_d;      // entries walked so far
	logic [CW-1:0] left_q, left_d;      // entries still to walk
	logic [15:0]   pos_q, pos_d;
	logic          found_q, found_d;
	olsk_pkg::status_t st_q, st_d;
	logic [VALUE_BITS-1:0] rv_q, rv_d;
	olsk_pkg::req_t req_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [15:0]   k_q;
	logic [5:0]    idx_q;
	olsk_pkg::out_word_t res_q, res_d;
	logic          ovalid_q, ovalid_d;
	olsk_pkg::cell_cmd_t cmd;
	logic          hit;
	logic [VALUE_BITS-1:0] in_val;

	assign in_val = VALUE_BITS'(in_data.value);

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [VALUE_BITS-1:0] upper;
			logic [VALUE_BITS-1:0] d_c;
			logic                  take_c;
			if (g == CAPACITY - 1) begin : g_last
				assign upper = cq[0];
			end else begin : g_mid
				assign upper = cq[g + 1];
			end
			// last held cell takes the front word on rotate; the rest take their neighbor
			assign d_c = cmd.load ? val_q : ((CW'(g + 1) == count_q) ? cq[0] : upper);
			assign take_c = (cmd.load && CW'(g) == count_q)
				|| (cmd.rotate && CW'(g) < count_q)
				|| (cmd.drop && CW'(g + 1) < count_q);
			olsk_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
				.clk  (clk),
				.take (take_c),
				.d    (d_c),
				.q    (cq[g])
			);
		end
	endgenerate

	assign in_stall = (state_q != olsk_pkg::FSM_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= olsk_pkg::FSM_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		step_q  <= step_d;
		left_q  <= left_d;
		pos_q   <= pos_d;
		found_q <= found_d;
		st_q    <= st_d;
		rv_q    <= rv_d;
		res_q   <= res_d;
		if (in_valid && !in_stall) begin
			req_q <= olsk_pkg::req_t'(in_data.req_type);
			val_q <= in_val;
			k_q   <= in_data.step_k;
			idx_q <= in_data.index;
		end
	end

	// The walk looks at the front cell each cycle: a kept word rotates to the
	// tail of the held block, a dropped one is shifted out. After all original
	// entries pass, the kept ones sit at the front in their old order.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		step_d   = step_q;
		left_d   = left_q;
		pos_d    = pos_q;
		found_d  = found_q;
		st_d     = st_q;
		rv_d     = rv_q;
		res_d    = res_q;
		ovalid_d = ovalid_q;
		cmd      = '0;
		hit      = 1'b0;
		if (ovalid_q && !out_stall) ovalid_d = 1'b0;
		case (state_q)
			olsk_pkg::FSM_IDLE: begin
				if (in_valid) begin
					state_d = olsk_pkg::FSM_WALK;
					step_d  = '0;
					left_d  = '0;
					pos_d   = '0;
					found_d = 1'b0;
					rv_d    = '0;
					st_d    = olsk_pkg::ST_OK;
					case (olsk_pkg::req_t'(in_data.req_type))
						olsk_pkg::REQ_APPEND: begin
							if (count_q >= CW'(CAPACITY)) st_d = olsk_pkg::ST_FULL;
						end
						olsk_pkg::REQ_REMOVE: begin
							if (count_q == '0) st_d = olsk_pkg::ST_EMPTY;
							else left_d = count_q;
						end
						olsk_pkg::REQ_KTH: begin
							if (count_q == '0) st_d = olsk_pkg::ST_EMPTY;
							else if (in_data.step_k <= 16'd1) st_d = olsk_pkg::ST_BAD_ARG;
							else left_d = count_q;
						end
						olsk_pkg::REQ_READ: begin
							if (count_q == '0) st_d = olsk_pkg::ST_EMPTY;
							else if (XW'(in_data.index) >= XW'(count_q))
								st_d = olsk_pkg::ST_BAD_ARG;
							else left_d = count_q;
						end
						default: ;
					endcase
				end
			end
			olsk_pkg::FSM_WALK: begin
				if (left_q != '0) begin
					step_d = step_q + 1'b1;
					left_d = left_q - 1'b1;
					case (req_q)
						olsk_pkg::REQ_REMOVE: begin
							hit = !found_q && (cq[0] == val_q);
							if (hit) found_d = 1'b1;
						end
						olsk_pkg::REQ_KTH: begin
							if (pos_q + 16'd1 == k_q) begin
								hit   = 1'b1;
								pos_d = '0;
							end else begin
								pos_d = pos_q + 16'd1;
							end
						end
						olsk_pkg::REQ_READ: begin
							if (XW'(step_q) == XW'(idx_q)) rv_d = cq[0];
						end
						default: ;
					endcase
					if (hit) begin
						cmd.drop = 1'b1;
						count_d  = count_q - 1'b1;
					end else begin
						cmd.rotate = 1'b1;
					end
				end else begin
					if (req_q == olsk_pkg::REQ_APPEND && st_q == olsk_pkg::ST_OK) begin
						cmd.load = 1'b1;
						count_d  = count_q + 1'b1;
					end
					if (req_q == olsk_pkg::REQ_REMOVE && st_q == olsk_pkg::ST_OK && !found_q)
						st_d = olsk_pkg::ST_NOT_FOUND;
					state_d = olsk_pkg::FSM_DONE;
				end
			end
			olsk_pkg::FSM_DONE: begin
				if (!ovalid_q || !out_stall) begin
					res_d.status     = st_q;
					res_d.length     = 7'(count_q);
					res_d.read_value = 32'(rv_q);
					ovalid_d         = 1'b1;
					state_d          = olsk_pkg::FSM_IDLE;
				end
			end
			default: state_d = olsk_pkg::FSM_IDLE;
		endcase
	end

	assign out_valid = ovalid_q;
	assign out_data  = res_q;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;

	localparam int DEPTH = olsk_pkg::CAPACITY_DEF;
	localparam int LIMIT = 4000000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	olsk_pkg::in_word_t in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	olsk_pkg::out_word_t out_data;

	ordered_list_store_with_kth_removal i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predicted store contents
	logic [31:0] store [DEPTH];
	int store_len;
	olsk_pkg::out_word_t pending[$];
	int errors = 0;
	int cycles = 0;
	bit gaps_on = 1'b1;
	int hold_req = 0;
	int hold_seen = 0;
	int stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic olsk_pkg::out_word_t apply_request(olsk_pkg::in_word_t w);
		olsk_pkg::out_word_t r;
		int wr;
		int pos;
		bit found;
		r = '0;
		case (olsk_pkg::req_t'(w.req_type))
			olsk_pkg::REQ_APPEND: begin
				if (store_len >= DEPTH) begin
					r.status = olsk_pkg::ST_FULL;
				end else begin
					store[store_len] = w.value;
					store_len++;
					r.status = olsk_pkg::ST_OK;
				end
			end
			olsk_pkg::REQ_REMOVE: begin
				if (store_len == 0) begin
					r.status = olsk_pkg::ST_EMPTY;
				end else begin
					found = 0;
					for (int i = 0; i < store_len; i++) begin
						if (!found && store[i] == w.value) begin
							found = 1;
							for (int j = i; j + 1 < store_len; j++)
								store[j] = store[j + 1];
						end
					end
					if (found) begin
						store_len--;
						r.status = olsk_pkg::ST_OK;
					end else begin
						r.status = olsk_pkg::ST_NOT_FOUND;
					end
				end
			end
			olsk_pkg::REQ_KTH: begin
				if (store_len == 0) begin
					r.status = olsk_pkg::ST_EMPTY;
				end else if (w.step_k <= 1) begin
					r.status = olsk_pkg::ST_BAD_ARG;
				end else begin
					wr = 0;
					pos = 0;
					for (int i = 0; i < store_len; i++) begin
						pos++;
						if (pos == w.step_k) begin
							pos = 0;
						end else begin
							store[wr] = store[i];
							wr++;
						end
					end
					store_len = wr;
					r.status = olsk_pkg::ST_OK;
				end
			end
			default: begin
				if (store_len == 0) begin
					r.status = olsk_pkg::ST_EMPTY;
				end else if (w.index >= store_len) begin
					r.status = olsk_pkg::ST_BAD_ARG;
				end else begin
					r.status = olsk_pkg::ST_OK;
					r.read_value = store[w.index];
				end
			end
		endcase
		r.length = store_len[6:0];
		return r;
	endfunction

	// valid stays up between words; it drops only for an idle gap or a drain
	task automatic send_word(olsk_pkg::in_word_t w);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending.push_back(apply_request(w));
	endtask

	task automatic send_req(olsk_pkg::req_t t, logic [31:0] v, logic [15:0] k,
		logic [5:0] idx);
		olsk_pkg::in_word_t w;
		w.req_type = t;
		w.value = v;
		w.step_k = k;
		w.index = idx;
		send_word(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	// pick a value likely present in the store
	function automatic logic [31:0] pick_value();
		if (store_len != 0 && $urandom_range(0, 3) != 0)
			return store[$urandom_range(0, store_len - 1)];
		return $urandom_range(0, 15);
	endfunction

	task automatic random_word();
		olsk_pkg::in_word_t w;
		int sel;
		w.value = $urandom();
		w.step_k = 16'($urandom());
		w.index = 6'($urandom());
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			w.req_type = olsk_pkg::REQ_APPEND;
			if ($urandom_range(0, 1)) w.value = $urandom_range(0, 15);
		end else if (sel < 60) begin
			w.req_type = olsk_pkg::REQ_REMOVE;
			w.value = pick_value();
		end else if (sel < 70) begin
			w.req_type = olsk_pkg::REQ_KTH;
			if ($urandom_range(0, 4) != 0) w.step_k = 16'($urandom_range(0, 10));
		end else begin
			w.req_type = olsk_pkg::REQ_READ;
			if ($urandom_range(0, 4) != 0)
				w.index = 6'($urandom_range(0, store_len));
		end
		send_word(w);
	endtask

	task automatic test_edges();
		send_req(olsk_pkg::REQ_REMOVE, 32'd5, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_KTH, 32'd0, 16'd2, 6'd0);
		send_req(olsk_pkg::REQ_READ, 32'd0, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 6'h3F);
		send_req(olsk_pkg::REQ_APPEND, 32'd0, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_APPEND, 32'd7, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_APPEND, 32'd7, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_READ, 32'd0, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_READ, 32'hFFFF_FFFF, 16'hFFFF, 6'd4);
		send_req(olsk_pkg::REQ_READ, 32'd0, 16'd0, 6'h3F);
		send_req(olsk_pkg::REQ_REMOVE, 32'd99, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_REMOVE, 32'd7, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_KTH, 32'd0, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_KTH, 32'd0, 16'd1, 6'd0);
		send_req(olsk_pkg::REQ_KTH, 32'd0, 16'hFFFF, 6'd0);
		send_req(olsk_pkg::REQ_KTH, 32'd0, 16'd2, 6'd0);
		send_req(olsk_pkg::REQ_READ, 32'd0, 16'd0, 6'd1);
	endtask

	task automatic test_full();
		while (store_len < DEPTH)
			send_req(olsk_pkg::REQ_APPEND, $urandom(), 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_APPEND, 32'h1234_5678, 16'd0, 6'd0);
		send_req(olsk_pkg::REQ_READ, 32'd0, 16'd0, 6'h3F);
		send_req(olsk_pkg::REQ_KTH, 32'd0, 16'd64, 6'd0);
		send_req(olsk_pkg::REQ_KTH, 32'd0, 16'd3, 6'd0);
	endtask

	task automatic test_backpressure();
		hold_req = hold_req + 1;
		repeat (20) random_word();
		drain();
	endtask

	task automatic test_random();
		for (int n = 0; n < 1050; n++) begin
			if (n == 500) drain();
			if (n == 850) gaps_on = 0;
			random_word();
		end
	endtask

	always @(posedge clk) begin
		olsk_pkg::out_word_t exp_w;
		if (out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$error("unexpected word %h", out_data);
				errors++;
			end else begin
				exp_w = pending.pop_front();
				if (out_data.status !== exp_w.status) begin
					$error("status exp %0d got %0d", exp_w.status, out_data.status);
					errors++;
				end
				if (out_data.length !== exp_w.length) begin
					$error("length exp %0d got %0d", exp_w.length, out_data.length);
					errors++;
				end
				if (out_data.read_value !== exp_w.read_value) begin
					$error("read_value exp %h got %h", exp_w.read_value,
						out_data.read_value);
					errors++;
				end
			end
		end
	end

	// receiver stall: random bursts while gaps are on, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			stall_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (gaps_on && !out_stall && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		store_len = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_full();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0 && pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
